>>> design/bole_pkg.sv
// ----------------------------------------------------------------------------
// bole_pkg: shared types for the bounded ordered list engine
// Request and result payloads, request and status codes, and the control
// word that the sequencer broadcasts to every list cell.
// ----------------------------------------------------------------------------
package bole_pkg;

    // request codes; 10 to 15 behave as a query
    typedef enum logic [3:0] {
        REQ_INS_FRONT = 4'd0,
        REQ_INS_BACK  = 4'd1,
        REQ_INS_SORT  = 4'd2,
        REQ_RM_FRONT  = 4'd3,
        REQ_RM_BACK   = 4'd4,
        REQ_RM_VALUE  = 4'd5,
        REQ_REVERSE   = 4'd6,
        REQ_SORT      = 4'd7,
        REQ_CLEAR     = 4'd8,
        REQ_QUERY     = 4'd9
    } t_req_code;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_DUP       = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    // one input transfer
    typedef struct packed {
        logic [3:0]         req_type;
        logic signed [31:0] value;
    } t_request;

    // one result transfer
    typedef struct packed {
        t_status            status;
        logic signed [31:0] out_value;
        logic [4:0]         count;
        logic               is_empty;
        logic               is_sorted;
    } t_result;

    // cell operations
    typedef enum logic [2:0] {
        CO_HOLD,
        CO_MARK,
        CO_SCAN,
        CO_INS,
        CO_DEL,
        CO_REV,
        CO_SORT
    } t_cell_op;

    // what a cell flags during a mark cycle
    typedef enum logic [1:0] {
        MK_ALL,
        MK_TAIL,
        MK_GE,
        MK_EQ
    } t_mark;

    typedef struct packed {
        t_cell_op op;
        t_mark    mark;
        logic     phase;
    } t_cell_ctl;

endpackage

>>> design/bole_cell.sv
// ----------------------------------------------------------------------------
// bole_cell: one list position
// Holds one entry and a position flag. Moves data to and from its two
// neighbors for shifts, prefix reversal and odd-even compare-exchange.
// ----------------------------------------------------------------------------
module bole_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int CNT_W      = 5,
    parameter int IDX        = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bole_pkg::t_cell_ctl          i_ctl,
    input  logic [CNT_W-1:0]             i_count,
    input  logic [CNT_W-1:0]             i_lim,
    input  logic signed [DATA_WIDTH-1:0] i_val,
    input  logic signed [DATA_WIDTH-1:0] i_head,
    input  logic signed [DATA_WIDTH-1:0] i_left,
    input  logic signed [DATA_WIDTH-1:0] i_right,
    input  logic                         i_left_flag,
    input  logic                         i_far,
    input  logic                         i_gt_right,
    output logic signed [DATA_WIDTH-1:0] o_data,
    output logic signed [DATA_WIDTH-1:0] o_tail,
    output logic                         o_flag,
    output logic                         o_gt,
    output logic                         o_dup,
    output logic                         o_ok
);
    import bole_pkg::*;

    localparam logic [CNT_W-1:0] POS   = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] NEXT  = CNT_W'(IDX + 1);
    localparam logic             ODD   = ((IDX % 2) == 1);
    localparam logic             FIRST = (IDX == 0);

    logic signed [DATA_WIDTH-1:0] r_data;
    logic signed [DATA_WIDTH-1:0] r_tail;
    logic signed [DATA_WIDTH-1:0] n_data;
    logic                         r_flag;
    logic                         n_flag;
    logic                         r_ok;
    logic                         w_valid;
    logic                         w_mark;
    logic                         w_pair_r;
    logic                         w_pair_l;

    assign w_valid = (POS < i_count);
    assign o_gt    = (i_left > r_data);
    assign o_data  = r_data;
    assign o_tail  = r_tail;
    assign o_flag  = r_flag;
    assign o_ok    = r_ok;

    // first flagged cell holding the search value
    assign o_dup = r_flag && !i_left_flag && w_valid && (r_data == i_val);

    // odd-even pairing for this phase
    assign w_pair_r = (ODD == i_ctl.phase) && (NEXT < i_count);
    assign w_pair_l = (ODD != i_ctl.phase) && !FIRST && w_valid;

    // mark condition
    always_comb begin
        case (i_ctl.mark)
            MK_ALL:  w_mark = 1'b1;
            MK_TAIL: w_mark = !w_valid;
            MK_GE:   w_mark = !w_valid || !(r_data < i_val);
            MK_EQ:   w_mark = w_valid && (r_data == i_val);
            default: w_mark = 1'b0;
        endcase
    end

    // next entry and flag
    always_comb begin
        n_data = r_data;
        n_flag = r_flag;
        case (i_ctl.op)
            CO_MARK: n_flag = w_mark;
            CO_SCAN: n_flag = r_flag | i_far;
            CO_INS: begin
                if (i_left_flag) begin
                    n_data = i_left;
                end else if (r_flag) begin
                    n_data = i_val;
                end
            end
            CO_DEL: begin
                if (r_flag) begin
                    n_data = i_right;
                end
            end
            CO_REV: begin
                if (POS < i_lim) begin
                    n_data = i_right;
                end else if (POS == i_lim) begin
                    n_data = i_head;
                end
            end
            CO_SORT: begin
                if (w_pair_r) begin
                    n_data = i_gt_right ? i_right : r_data;
                end else if (w_pair_l) begin
                    n_data = o_gt ? i_left : r_data;
                end
            end
            default: ;
        endcase
    end

    // entry storage, no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_tail <= (NEXT == i_count) ? r_data : '0;
    end

    // flag and order status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
            r_ok   <= 1'b1;
        end else begin
            r_flag <= n_flag;
            r_ok   <= FIRST || !(w_valid && o_gt);
        end
    end

endmodule

>>> design/bounded_ordered_list_engine.sv
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine: bounded list of signed words in a cell chain
// A request is accepted when start is high and busy is low. One result per
// request appears on o_res for one cycle with o_strobe high; it cannot be held.
// Steps after the accepting edge, each request ending in a check and a report step:
//   refused at accept, clear, query, remove back,
//   reverse or sort of fewer than two entries:  no further step
//   insert front/back, remove front:            an apply step
//   sorted insert, remove value:                scan, decide and apply,
//                                               no apply if duplicate
//                                               or not found
//   reverse:                                    repeated prefix reversals
//   sort:                                       odd-even exchange rounds
// The cell chain does the work: data moves one neighbor per cycle, the
// match prefix is built by a doubling scan, and sorting runs count
// odd-even exchange rounds.
// busy drops in the strobe cycle, so the next request may be accepted while
// the result is shown. One request is in work at a time.
// Reset empties the list at once; entries themselves are not cleared.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  bole_pkg::t_request i_req,
    output logic               o_strobe,
    output bole_pkg::t_result  o_res
);
    import bole_pkg::*;

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SCAN_N = $clog2(DEPTH);
    localparam int STEP_W = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO      = CNT_W'(2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_APPLY,
        S_REV,
        S_SORT,
        S_CHECK,
        S_REPORT
    } t_state;

    t_state                       r_state;
    logic [3:0]                   r_req;
    logic signed [DATA_WIDTH-1:0] r_val;
    logic signed [DATA_WIDTH-1:0] r_out;
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             r_lim;
    logic [STEP_W-1:0]            r_step;
    logic                         r_phase;
    t_status                      r_status;
    logic                         r_strobe;
    t_result                      r_res;

    t_cell_ctl                    w_ctl;
    t_mark                        w_mark;
    logic signed [DATA_WIDTH-1:0] w_in_val;
    logic signed [DATA_WIDTH-1:0] w_val;
    logic signed [DATA_WIDTH-1:0] w_tail_or;
    logic signed [31:0]           w_out_ext;
    logic [4:0]                   w_count_ext;
    logic signed [DATA_WIDTH-1:0] w_data [DEPTH];
    logic signed [DATA_WIDTH-1:0] w_tail [DEPTH];
    wire  [DEPTH-1:0]             w_flag;
    wire  [DEPTH-1:0]             w_gt;
    wire  [DEPTH-1:0]             w_dup;
    wire  [DEPTH-1:0]             w_ok;
    logic                         w_full;
    logic                         w_empty;

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;
    assign w_full   = (r_count == FULL_CNT);
    assign w_empty  = (r_count == '0);

    // input value to list width, result value to port width
    if (DATA_WIDTH <= 32) begin : g_in_narrow
        assign w_in_val = i_req.value[DATA_WIDTH-1:0];
    end else begin : g_in_wide
        assign w_in_val = {{(DATA_WIDTH - 32){i_req.value[31]}}, i_req.value};
    end

    if (DATA_WIDTH >= 32) begin : g_out_narrow
        assign w_out_ext = r_out[31:0];
    end else begin : g_out_wide
        assign w_out_ext = {{(32 - DATA_WIDTH){r_out[DATA_WIDTH-1]}}, r_out};
    end

    if (CNT_W >= 5) begin : g_cnt_narrow
        assign w_count_ext = r_count[4:0];
    end else begin : g_cnt_wide
        assign w_count_ext = {{(5 - CNT_W){1'b0}}, r_count};
    end

    // mark kind for the request being offered
    always_comb begin
        case (i_req.req_type)
            REQ_INS_BACK: w_mark = MK_TAIL;
            REQ_INS_SORT: w_mark = MK_GE;
            REQ_RM_VALUE: w_mark = MK_EQ;
            default:      w_mark = MK_ALL;
        endcase
    end

    // control word broadcast to the chain
    always_comb begin
        w_ctl.mark  = w_mark;
        w_ctl.phase = r_phase;
        case (r_state)
            S_IDLE:  w_ctl.op = CO_MARK;
            S_SCAN:  w_ctl.op = CO_SCAN;
            S_APPLY: begin
                if (r_req == REQ_INS_FRONT || r_req == REQ_INS_BACK ||
                    r_req == REQ_INS_SORT) begin
                    w_ctl.op = CO_INS;
                end else begin
                    w_ctl.op = CO_DEL;
                end
            end
            S_REV:   w_ctl.op = CO_REV;
            S_SORT:  w_ctl.op = CO_SORT;
            default: w_ctl.op = CO_HOLD;
        endcase
    end

    assign w_val = (r_state == S_IDLE) ? w_in_val : r_val;

    // value of the last entry
    always_comb begin
        w_tail_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_tail_or = w_tail_or | w_tail[i];
        end
    end

    // cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_WIDTH-1:0] l_left;
        logic signed [DATA_WIDTH-1:0] l_right;
        logic                         l_left_flag;
        logic                         l_gt_right;
        logic                         l_far;

        if (g == 0) begin : g_first
            assign l_left      = '0;
            assign l_left_flag = 1'b0;
        end else begin : g_mid_l
            assign l_left      = w_data[g-1];
            assign l_left_flag = w_flag[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign l_right    = '0;
            assign l_gt_right = 1'b0;
        end else begin : g_mid_r
            assign l_right    = w_data[g+1];
            assign l_gt_right = w_gt[g+1];
        end

        // doubling scan: step k pulls the flag from 2^k cells to the left
        always_comb begin
            l_far = 1'b0;
            for (int k = 0; k < SCAN_N; k++) begin
                if (r_step == STEP_W'(k) && g >= (1 << k)) begin
                    l_far = w_flag[(g >= (1 << k)) ? (g - (1 << k)) : 0];
                end
            end
        end

        bole_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .IDX        (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_count     (r_count),
            .i_lim       (r_lim),
            .i_val       (w_val),
            .i_head      (w_data[0]),
            .i_left      (l_left),
            .i_right     (l_right),
            .i_left_flag (l_left_flag),
            .i_far       (l_far),
            .i_gt_right  (l_gt_right),
            .o_data      (w_data[g]),
            .o_tail      (w_tail[g]),
            .o_flag      (w_flag[g]),
            .o_gt        (w_gt[g]),
            .o_dup       (w_dup[g]),
            .o_ok        (w_ok[g])
        );
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_lim    <= '0;
            r_step   <= '0;
            r_phase  <= 1'b0;
            r_status <= ST_OK;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_req    <= i_req.req_type;
                        r_val    <= w_in_val;
                        r_out    <= '0;
                        r_status <= ST_OK;
                        r_step   <= '0;
                        r_phase  <= 1'b0;
                        r_state  <= S_CHECK;
                        case (i_req.req_type)
                            REQ_INS_FRONT, REQ_INS_BACK: begin
                                if (w_full) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_state <= S_APPLY;
                                end
                            end
                            REQ_INS_SORT: begin
                                if (w_full) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            REQ_RM_FRONT: begin
                                if (w_empty) begin
                                    r_status <= ST_EMPTY;
                                end else begin
                                    r_out   <= w_data[0];
                                    r_state <= S_APPLY;
                                end
                            end
                            REQ_RM_BACK: begin
                                if (w_empty) begin
                                    r_status <= ST_EMPTY;
                                end else begin
                                    r_out   <= w_tail_or;
                                    r_count <= r_count - ONE;
                                end
                            end
                            REQ_RM_VALUE: begin
                                if (w_empty) begin
                                    r_status <= ST_EMPTY;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            REQ_REVERSE: begin
                                if (r_count >= TWO) begin
                                    r_lim   <= r_count - ONE;
                                    r_state <= S_REV;
                                end
                            end
                            REQ_SORT: begin
                                if (r_count >= TWO) begin
                                    r_lim   <= r_count;
                                    r_state <= S_SORT;
                                end
                            end
                            REQ_CLEAR: r_count <= '0;
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(SCAN_N - 1)) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_state <= S_APPLY;
                    if (r_req == REQ_INS_SORT && (|w_dup)) begin
                        r_status <= ST_DUP;
                        r_state  <= S_CHECK;
                    end else if (r_req == REQ_RM_VALUE && !w_flag[DEPTH-1]) begin
                        r_status <= ST_NOT_FOUND;
                        r_state  <= S_CHECK;
                    end
                end
                S_APPLY: begin
                    if (r_req == REQ_INS_FRONT || r_req == REQ_INS_BACK ||
                        r_req == REQ_INS_SORT) begin
                        r_count <= r_count + ONE;
                    end else begin
                        r_count <= r_count - ONE;
                    end
                    r_state <= S_CHECK;
                end
                S_REV: begin
                    r_lim <= r_lim - ONE;
                    if (r_lim == ONE) begin
                        r_state <= S_CHECK;
                    end
                end
                S_SORT: begin
                    r_lim   <= r_lim - ONE;
                    r_phase <= !r_phase;
                    if (r_lim == ONE) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: r_state <= S_REPORT;
                S_REPORT: begin
                    r_res.status    <= r_status;
                    r_res.out_value <= w_out_ext;
                    r_res.count     <= w_count_ext;
                    r_res.is_empty  <= w_empty;
                    r_res.is_sorted <= &w_ok;
                    r_strobe        <= 1'b1;
                    r_state         <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    // the list never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count above depth");

    // an applied insert or removal always moves the count
    a_apply_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_APPLY |=> r_count != $past(r_count))
        else $error("apply cycle left count unchanged");

    // an accepted request makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not start work");

    // a result is shown only once work is done
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> !busy)
        else $error("result shown while busy");

    // the empty flag agrees with the count it was taken from
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (r_res.is_empty == (r_count == '0)))
        else $error("empty flag disagrees with count");
`endif

endmodule

>>> tb/bounded_ordered_list_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_tb: self-checking bench for the ordered list
// A short table of directed requests walks the empty, full, duplicate and
// not-found cases. Random requests follow, in grow and shrink stretches so
// that the list swings between empty and full. A local copy of the list
// predicts the results that the table does not give; each is compared field by field at its strobe.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine_tb;
    import bole_pkg::*;

    localparam int DEPTH        = 16;
    localparam int DATA_WIDTH   = 32;
    localparam int N_RANDOM     = 1750;
    localparam int SETTLE_CYC   = 2 * DEPTH + 8;
    localparam logic [3:0] REQ_FIRST_UNUSED = 4'd10;
    localparam logic [3:0] REQ_LAST_UNUSED  = 4'd15;
    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

    // one row of the directed table
    typedef struct {
        logic [3:0]         code;
        logic signed [31:0] value;
        int                 reps;
        bit                 typed;
        t_result            want;
    } t_stim_row;

    logic     clk     = 1'b0;
    logic     rst_n   = 1'b0;
    logic     start   = 1'b0;
    t_request req     = '0;
    logic     busy;
    logic     o_strobe;
    t_result  o_res;

    // local copy of the list
    logic signed [31:0] list_words [DEPTH];
    int                 list_len = 0;

    t_result   pending_results [$];
    t_stim_row stim_table [$];
    int        mismatches = 0;

    always #4 clk = ~clk;

    bounded_ordered_list_engine #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (req),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    function automatic t_result res_of(t_status st, logic signed [31:0] v,
                                       logic [4:0] cnt, logic emp, logic srt);
        t_result r;
        r.status    = st;
        r.out_value = v;
        r.count     = cnt;
        r.is_empty  = emp;
        r.is_sorted = srt;
        return r;
    endfunction

    // shift entries pos.. up by one
    function automatic void open_gap(input int pos);
        for (int j = list_len; j > pos; j--)
            list_words[j] = list_words[j - 1];
    endfunction

    // shift entries above pos down by one
    function automatic void close_gap(input int pos);
        for (int j = pos; j + 1 < list_len; j++)
            list_words[j] = list_words[j + 1];
    endfunction

    // apply one request to the local list and return its result
    function automatic t_result apply_request(input t_request r);
        t_result            res;
        int                 pos;
        logic signed [31:0] tmp;
        bit                 ordered;

        res        = '0;
        res.status = ST_OK;
        case (r.req_type)
            REQ_INS_FRONT, REQ_INS_BACK: begin
                if (list_len >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    pos = (r.req_type == REQ_INS_FRONT) ? 0 : list_len;
                    open_gap(pos);
                    list_words[pos] = r.value;
                    list_len++;
                end
            end
            REQ_INS_SORT: begin
                if (list_len >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < list_len && list_words[pos] < r.value)
                        pos++;
                    if (pos < list_len && list_words[pos] == r.value) begin
                        res.status = ST_DUP;
                    end else begin
                        open_gap(pos);
                        list_words[pos] = r.value;
                        list_len++;
                    end
                end
            end
            REQ_RM_FRONT, REQ_RM_BACK: begin
                if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else if (r.req_type == REQ_RM_FRONT) begin
                    res.out_value = list_words[0];
                    close_gap(0);
                    list_len--;
                end else begin
                    res.out_value = list_words[list_len - 1];
                    list_len--;
                end
            end
            REQ_RM_VALUE: begin
                if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    pos = 0;
                    while (pos < list_len && list_words[pos] != r.value)
                        pos++;
                    if (pos == list_len) begin
                        res.status = ST_NOT_FOUND;
                    end else begin
                        close_gap(pos);
                        list_len--;
                    end
                end
            end
            REQ_REVERSE: begin
                for (int i = 0; i < list_len / 2; i++) begin
                    tmp                          = list_words[i];
                    list_words[i]                = list_words[list_len - 1 - i];
                    list_words[list_len - 1 - i] = tmp;
                end
            end
            REQ_SORT: begin
                // insertion sort, ascending
                for (int i = 1; i < list_len; i++) begin
                    tmp = list_words[i];
                    pos = i;
                    while (pos > 0 && list_words[pos - 1] > tmp) begin
                        list_words[pos] = list_words[pos - 1];
                        pos--;
                    end
                    list_words[pos] = tmp;
                end
            end
            REQ_CLEAR: list_len = 0;
            default: ;
        endcase

        ordered = 1'b1;
        for (int i = 1; i < list_len; i++)
            if (list_words[i - 1] > list_words[i])
                ordered = 1'b0;
        res.count     = 5'(list_len);
        res.is_empty  = (list_len == 0);
        res.is_sorted = ordered;
        return res;
    endfunction

    // value mix: small values for duplicates, extremes, full range
    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = $signed($urandom_range(0, 8)) - 4;
            2: begin
                case ($urandom_range(0, 3))
                    0: v = WORD_MIN;
                    1: v = WORD_MAX;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // request mix leaning toward inserts while growing, removals otherwise
    function automatic t_request pick_request(input bit grow);
        t_request r;
        int       sel;

        sel     = $urandom_range(0, 99);
        r.value = pick_value();
        if (sel < (grow ? 60 : 20))
            r.req_type = 4'($urandom_range(REQ_INS_FRONT, REQ_INS_SORT));
        else if (sel < 80)
            r.req_type = 4'($urandom_range(REQ_RM_FRONT, REQ_RM_VALUE));
        else if (sel < 88)
            r.req_type = REQ_REVERSE;
        else if (sel < 93)
            r.req_type = REQ_SORT;
        else if (sel < 95)
            r.req_type = REQ_CLEAR;
        else if (sel < 97)
            r.req_type = REQ_QUERY;
        else
            r.req_type = 4'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_UNUSED));

        // aim value removals and sorted inserts at present entries
        if ((r.req_type == REQ_RM_VALUE || r.req_type == REQ_INS_SORT)
                && list_len > 0 && $urandom_range(0, 9) < 6)
            r.value = list_words[$urandom_range(0, list_len - 1)];
        return r;
    endfunction

    task automatic add_row(input logic [3:0] code, input logic signed [31:0] value,
                           input int reps, input bit typed, input t_result want);
        t_stim_row row;
        row.code  = code;
        row.value = value;
        row.reps  = reps;
        row.typed = typed;
        row.want  = want;
        stim_table.push_back(row);
    endtask

    // hold start until the transfer happens, then record what is expected
    task automatic send(input t_request r, input bit typed, input t_result want);
        t_result pred;
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy !== 1'b0);
        pred = apply_request(r);
        pending_results.push_back(typed ? want : pred);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // result checking
    always @(posedge clk) begin : check_results
        t_result want;
        if (rst_n && o_strobe !== 1'b0) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result strobe with nothing pending");
            end else begin
                want = pending_results.pop_front();
                if (o_res.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              o_res.status, want.status));
                if (o_res.out_value !== want.out_value)
                    report_mismatch($sformatf("out_value %h, want %h",
                                              o_res.out_value, want.out_value));
                if (o_res.count !== want.count)
                    report_mismatch($sformatf("count %0d, want %0d",
                                              o_res.count, want.count));
                if (o_res.is_empty !== want.is_empty)
                    report_mismatch($sformatf("is_empty %b, want %b",
                                              o_res.is_empty, want.is_empty));
                if (o_res.is_sorted !== want.is_sorted)
                    report_mismatch($sformatf("is_sorted %b, want %b",
                                              o_res.is_sorted, want.is_sorted));
            end
        end
    end

    // stimulus
    initial begin : drive_requests
        t_request  r;
        t_stim_row row;
        t_result   none;
        int        sent;
        int        burst;
        int        gap;
        int        epoch;
        bit        grow;

        none = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list, extremes, every request, refusals, full list
        add_row(REQ_QUERY,       0,        1, 1, res_of(ST_OK, 0, 0, 1, 1));
        add_row(REQ_LAST_UNUSED, 0,        1, 1, res_of(ST_OK, 0, 0, 1, 1));
        add_row(REQ_RM_FRONT,    0,        1, 1, res_of(ST_EMPTY, 0, 0, 1, 1));
        add_row(REQ_RM_BACK,     0,        1, 1, res_of(ST_EMPTY, 0, 0, 1, 1));
        add_row(REQ_RM_VALUE,    0,        1, 1, res_of(ST_EMPTY, 0, 0, 1, 1));
        add_row(REQ_INS_BACK,    WORD_MAX, 1, 1, res_of(ST_OK, 0, 1, 0, 1));
        add_row(REQ_INS_FRONT,   WORD_MIN, 1, 1, res_of(ST_OK, 0, 2, 0, 1));
        add_row(REQ_INS_SORT,    0,        1, 1, res_of(ST_OK, 0, 3, 0, 1));
        add_row(REQ_INS_SORT,    0,        1, 1, res_of(ST_DUP, 0, 3, 0, 1));
        add_row(REQ_RM_VALUE,    5,        1, 1, res_of(ST_NOT_FOUND, 0, 3, 0, 1));
        add_row(REQ_REVERSE,     0,        1, 0, none);
        add_row(REQ_SORT,        0,        1, 0, none);
        add_row(REQ_RM_FRONT,    0,        1, 1, res_of(ST_OK, WORD_MIN, 2, 0, 1));
        add_row(REQ_INS_BACK,    -1,       1, 0, none);
        add_row(REQ_RM_VALUE,    WORD_MAX, 1, 0, none);
        add_row(REQ_INS_FRONT,   3,       14, 0, none);
        add_row(REQ_INS_BACK,    1,        1, 0, none);
        // full and duplicate at once: full wins
        add_row(REQ_INS_SORT,    3,        1, 0, none);
        add_row(REQ_INS_FRONT,   5,        1, 0, none);
        add_row(REQ_SORT,        0,        1, 0, none);
        add_row(REQ_RM_BACK,     0,        1, 0, none);
        add_row(REQ_CLEAR,       0,        1, 1, res_of(ST_OK, 0, 0, 1, 1));

        foreach (stim_table[i]) begin
            row = stim_table[i];
            r.req_type = row.code;
            r.value    = row.value;
            for (int k = 0; k < row.reps; k++)
                send(r, row.typed, row.want);
        end

        // let the pipeline empty before the random part
        start <= 1'b0;
        wait_drained();
        @(posedge clk);

        // random part in bursts, alternating grow and shrink stretches
        sent  = 0;
        grow  = 1'b1;
        epoch = $urandom_range(10, 60);
        while (sent < N_RANDOM) begin
            burst = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
            for (int b = 0; b < burst && sent < N_RANDOM; b++) begin
                send(pick_request(grow), 1'b0, none);
                sent++;
                epoch--;
                if (epoch == 0) begin
                    grow  = ~grow;
                    epoch = $urandom_range(10, 60);
                end
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if ($urandom_range(0, 19) == 0) begin
                start <= 1'b0;
                wait_drained();
            end else if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end

        start <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYC) @(posedge clk);

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // run limit
    initial begin : run_limit
        #4ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
design/bole_pkg.sv
design/bole_cell.sv
design/bounded_ordered_list_engine.sv
tb/bounded_ordered_list_engine_tb.sv
